### rtl/symmetric_5x5_convolution_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the symmetric 5x5 convolution block
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_5X5_CONVOLUTION_TOP_ASSERT_SVH
`define SYMMETRIC_5X5_CONVOLUTION_TOP_ASSERT_SVH

// same-cycle implication
`define SC5_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SC5_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sc5_pkg.sv
// ----------------------------------------------------------------------------
// sc5_pkg
// Shared types, register indexes and the border mirror tap map.
// ----------------------------------------------------------------------------
package sc5_pkg;

    localparam int TAPS         = 5;
    localparam int LINES        = 4;
    localparam int NCLS         = 6;
    localparam int ROW_BITS     = 16;
    localparam int COL_MAX_BITS = 13;
    localparam int FW_BITS      = 12;
    localparam int FH_BITS      = 16;

    // configuration register indexes
    localparam logic [2:0] REG_FRAME_WIDTH     = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_WEIGHT_CENTER   = 3'd2;
    localparam logic [2:0] REG_WEIGHT_AXIS_ONE = 3'd3;
    localparam logic [2:0] REG_WEIGHT_AXIS_TWO = 3'd4;
    localparam logic [2:0] REG_WEIGHT_DIAG_ONE = 3'd5;
    localparam logic [2:0] REG_WEIGHT_KNIGHT   = 3'd6;
    localparam logic [2:0] REG_WEIGHT_DIAG_TWO = 3'd7;

    // kernel distance classes
    localparam int CLS_CENTER   = 0;
    localparam int CLS_AXIS_ONE = 1;
    localparam int CLS_AXIS_TWO = 2;
    localparam int CLS_DIAG_ONE = 3;
    localparam int CLS_KNIGHT   = 4;
    localparam int CLS_DIAG_TWO = 5;

    typedef logic [2:0]              t_tap;
    typedef logic [ROW_BITS-1:0]     t_row;
    typedef logic [COL_MAX_BITS-1:0] t_col;

    typedef struct packed {
        t_row row;
        t_col col;
        logic run_last;
        logic frame_done;
    } t_meta;

    // k is the unmirrored window index (0..6). Low border applies when the
    // window position is 2 or 3, high border only shows up as k >= 5.
    function automatic t_tap mirror_tap(input t_tap k, input logic at_two,
                                        input logic at_three);
        t_tap tap;
        case (k)
            3'd0:    tap = at_two ? 3'd3 : (at_three ? 3'd1 : 3'd0);
            3'd1:    tap = at_two ? 3'd2 : 3'd1;
            3'd2:    tap = 3'd2;
            3'd3:    tap = 3'd3;
            3'd5:    tap = 3'd4;
            3'd6:    tap = 3'd3;
            default: tap = 3'd4;
        endcase
        return tap;
    endfunction

endpackage

### rtl/sc5_line_buf.sv
// ----------------------------------------------------------------------------
// sc5_line_buf
// Four line memories; one lane written, all lanes read at the same column.
// ----------------------------------------------------------------------------
module sc5_line_buf #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WIDTH   = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_addr,
    input  logic [1:0]                    i_lane,
    input  logic signed [SAMPLE_BITS-1:0] i_data,
    output logic signed [SAMPLE_BITS-1:0] o_data [sc5_pkg::LINES]
);

    for (genvar l = 0; l < sc5_pkg::LINES; l++) begin : g_lane
        logic signed [SAMPLE_BITS-1:0] r_mem [MAX_WIDTH];
        logic signed [SAMPLE_BITS-1:0] r_rd;

        // read returns the old word on a same-address write
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_lane == 2'(l)) begin
                    r_mem[i_addr] <= i_data;
                end
                r_rd <= r_mem[i_addr];
            end
        end

        assign o_data[l] = r_rd;
    end

endmodule

### rtl/sc5_cell.sv
// ----------------------------------------------------------------------------
// sc5_cell
// One window column: shifts to its left neighbor and picks mirrored rows.
// ----------------------------------------------------------------------------
module sc5_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic signed [SAMPLE_BITS-1:0] i_col     [sc5_pkg::TAPS],
    output logic signed [SAMPLE_BITS-1:0] o_col     [sc5_pkg::TAPS],
    input  logic                          i_capture,
    input  sc5_pkg::t_tap                 i_row_tap [sc5_pkg::TAPS],
    output logic signed [SAMPLE_BITS-1:0] o_sel     [sc5_pkg::TAPS]
);

    logic signed [SAMPLE_BITS-1:0] r_col [sc5_pkg::TAPS];
    logic signed [SAMPLE_BITS-1:0] r_sel [sc5_pkg::TAPS];

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
        if (i_capture) begin
            for (int d = 0; d < sc5_pkg::TAPS; d++) begin
                r_sel[d] <= r_col[i_row_tap[d]];
            end
        end
    end

    assign o_col = r_col;
    assign o_sel = r_sel;

endmodule

### rtl/sc5_mac.sv
// ----------------------------------------------------------------------------
// sc5_mac
// Column pick and class pre-add, six multiplies, sum, round and saturate.
// ----------------------------------------------------------------------------
module sc5_mac #(
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  sc5_pkg::t_meta                i_meta,
    input  sc5_pkg::t_tap                 i_col_tap [sc5_pkg::TAPS],
    input  logic signed [SAMPLE_BITS-1:0] i_sel     [sc5_pkg::TAPS][sc5_pkg::TAPS],
    input  logic signed [WEIGHT_BITS-1:0] i_weight  [sc5_pkg::NCLS],
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_pixel,
    output sc5_pkg::t_meta                o_meta
);

    localparam int PS = SAMPLE_BITS + 3;
    localparam int PW = PS + WEIGHT_BITS;
    localparam int AW = PW + 3;
    localparam int F  = WEIGHT_BITS - 2;
    localparam int QW = AW - F;
    localparam logic signed [AW-1:0] RND = {{(AW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    logic r_v1, r_v2, r_v3, r_v4;
    sc5_pkg::t_meta r_m1, r_m2, r_m3, r_m4;
    sc5_pkg::t_tap  r_tap1 [sc5_pkg::TAPS];

    logic signed [SAMPLE_BITS-1:0] s_pick [sc5_pkg::TAPS][sc5_pkg::TAPS];
    logic signed [PS-1:0] n_cs [sc5_pkg::NCLS];
    logic signed [PS-1:0] r_cs [sc5_pkg::NCLS];
    logic signed [PW-1:0] r_p  [sc5_pkg::NCLS];
    logic signed [AW-1:0] r_acc;
    logic [QW-1:0] q;
    logic          ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // s_pick[d][e]: row offset d, column offset e (2 is the center)
    always_comb begin
        for (int d = 0; d < sc5_pkg::TAPS; d++) begin
            for (int e = 0; e < sc5_pkg::TAPS; e++) begin
                s_pick[d][e] = i_sel[r_tap1[e]][d];
            end
        end
        n_cs[sc5_pkg::CLS_CENTER]   = PS'(s_pick[2][2]);
        n_cs[sc5_pkg::CLS_AXIS_ONE] = PS'(s_pick[1][2]) + PS'(s_pick[3][2])
                                    + PS'(s_pick[2][1]) + PS'(s_pick[2][3]);
        n_cs[sc5_pkg::CLS_AXIS_TWO] = PS'(s_pick[0][2]) + PS'(s_pick[4][2])
                                    + PS'(s_pick[2][0]) + PS'(s_pick[2][4]);
        n_cs[sc5_pkg::CLS_DIAG_ONE] = PS'(s_pick[1][1]) + PS'(s_pick[1][3])
                                    + PS'(s_pick[3][1]) + PS'(s_pick[3][3]);
        n_cs[sc5_pkg::CLS_KNIGHT]   = PS'(s_pick[0][1]) + PS'(s_pick[0][3])
                                    + PS'(s_pick[4][1]) + PS'(s_pick[4][3])
                                    + PS'(s_pick[1][0]) + PS'(s_pick[3][0])
                                    + PS'(s_pick[1][4]) + PS'(s_pick[3][4]);
        n_cs[sc5_pkg::CLS_DIAG_TWO] = PS'(s_pick[0][0]) + PS'(s_pick[0][4])
                                    + PS'(s_pick[4][0]) + PS'(s_pick[4][4]);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m1   <= i_meta;
            r_tap1 <= i_col_tap;
            r_m2   <= r_m1;
            r_cs   <= n_cs;
            r_m3   <= r_m2;
            for (int c = 0; c < sc5_pkg::NCLS; c++) begin
                r_p[c] <= PW'(r_cs[c]) * PW'(i_weight[c]);
            end
            r_m4  <= r_m3;
            r_acc <= AW'(r_p[0]) + AW'(r_p[1]) + AW'(r_p[2]) + AW'(r_p[3])
                   + AW'(r_p[4]) + AW'(r_p[5]) + RND;
        end
    end

    // floor shift, then clip to the sample range
    assign q   = r_acc[AW-1:F];
    assign ovf = !((&q[QW-1:SAMPLE_BITS-1]) || !(|q[QW-1:SAMPLE_BITS-1]));

    assign o_valid = r_v4;
    assign o_meta  = r_m4;
    assign o_pixel = ovf ? (q[QW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_BITS-1){1'b1}}})
                         : q[SAMPLE_BITS-1:0];

endmodule

### rtl/symmetric_5x5_convolution_top.sv
// ----------------------------------------------------------------------------
// symmetric_5x5_convolution_top
// Streaming 5x5 symmetric filter with mirrored borders.
//
//   channel   signals                                  direction
//   pixel     i_pix_valid / o_pix_ready / i_pixel_in    in
//   result    o_res_valid / i_res_ready / o_pixel_out.. out
//   config    i_cfg_we / i_cfg_idx / i_cfg_data         in, write only
//
// One sample per cycle is taken while each sample yields at most one result
// and the output queue has room. Row ends yield 3 results, last-row samples
// 3, the final sample 9; the window holds the sample until its results are
// issued, one per cycle while the queue has room. Reset is synchronous.
// A 2-entry output queue absorbs stalls; the pipeline halts when it is full.
// ----------------------------------------------------------------------------
`include "symmetric_5x5_convolution_top_assert.svh"

module symmetric_5x5_convolution_top #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [((WEIGHT_BITS > 16) ? WEIGHT_BITS : 16)-1:0] i_cfg_data,
    input  logic                          i_pix_valid,
    output logic                          o_pix_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_pixel_in,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic signed [SAMPLE_BITS-1:0] o_pixel_out,
    output logic [15:0]                   o_out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_out_col,
    output logic                          o_run_last,
    output logic                          o_frame_done
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int CW   = (XW + 1 > sc5_pkg::FW_BITS) ? XW + 1 : sc5_pkg::FW_BITS;
    localparam int TAPS = sc5_pkg::TAPS;

    // configuration
    logic [sc5_pkg::FW_BITS-1:0]   r_frame_width;
    logic [sc5_pkg::FH_BITS-1:0]   r_frame_height;
    logic signed [WEIGHT_BITS-1:0] r_weight [sc5_pkg::NCLS];

    logic [CW-1:0] fw_c, w_eff;
    logic [15:0]   h_eff;

    // input counters and hold stage
    logic [XW-1:0] r_x;
    logic [15:0]   r_y;
    logic          x_last, y_last, acc;

    logic                          r_b_valid;
    logic signed [SAMPLE_BITS-1:0] r_b_pix;
    logic [XW-1:0]                 r_b_x;
    logic [15:0]                   r_b_y;
    logic                          r_b_xl, r_b_yl;
    logic signed [SAMPLE_BITS-1:0] lb_rd [sc5_pkg::LINES];

    // result job
    logic          r_act, r_rn_two, r_cn_two, r_jlast;
    logic [1:0]    r_ri, r_ci;
    logic [15:0]   r_jy;
    logic [XW-1:0] r_jx;
    logic          adv, issue, ri_end, ci_end, issue_last, b_load;
    sc5_pkg::t_meta issue_meta;

    // window chain
    logic signed [SAMPLE_BITS-1:0] new_col  [TAPS];
    logic signed [SAMPLE_BITS-1:0] cell_col [TAPS][TAPS];
    logic signed [SAMPLE_BITS-1:0] cell_sel [TAPS][TAPS];
    sc5_pkg::t_tap row_tap [TAPS];
    sc5_pkg::t_tap col_tap [TAPS];

    // output queue
    logic                          mac_valid, push, pop;
    logic signed [SAMPLE_BITS-1:0] mac_pixel;
    sc5_pkg::t_meta                mac_meta;
    logic [1:0]                    r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_q_pix  [2];
    sc5_pkg::t_meta                r_q_meta [2];

    // ---------------------------------------------------------------- sizes
    assign fw_c  = CW'(r_frame_width);
    assign w_eff = (fw_c < CW'(3)) ? CW'(3) : ((fw_c > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : fw_c);
    assign h_eff = (r_frame_height < 16'd3) ? 16'd3 : r_frame_height;

    assign x_last = (CW'(r_x) == w_eff - CW'(1));
    assign y_last = (r_y == h_eff - 16'd1);

    assign o_pix_ready = !r_b_valid || b_load;
    assign acc         = i_pix_valid && o_pix_ready;

    // ------------------------------------------------- config and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sc5_pkg::FW_BITS'(2048);
            r_frame_height <= 16'd3;
            for (int c = 0; c < sc5_pkg::NCLS; c++) begin
                r_weight[c] <= (c == sc5_pkg::CLS_CENTER)
                             ? {2'b01, {(WEIGHT_BITS-2){1'b0}}} : '0;
            end
            r_x <= '0;
            r_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sc5_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[sc5_pkg::FW_BITS-1:0];
                    r_x <= '0;
                    r_y <= '0;
                end
                sc5_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[sc5_pkg::FH_BITS-1:0];
                    r_x <= '0;
                    r_y <= '0;
                end
                sc5_pkg::REG_WEIGHT_CENTER:
                    r_weight[sc5_pkg::CLS_CENTER]   <= i_cfg_data[WEIGHT_BITS-1:0];
                sc5_pkg::REG_WEIGHT_AXIS_ONE:
                    r_weight[sc5_pkg::CLS_AXIS_ONE] <= i_cfg_data[WEIGHT_BITS-1:0];
                sc5_pkg::REG_WEIGHT_AXIS_TWO:
                    r_weight[sc5_pkg::CLS_AXIS_TWO] <= i_cfg_data[WEIGHT_BITS-1:0];
                sc5_pkg::REG_WEIGHT_DIAG_ONE:
                    r_weight[sc5_pkg::CLS_DIAG_ONE] <= i_cfg_data[WEIGHT_BITS-1:0];
                sc5_pkg::REG_WEIGHT_KNIGHT:
                    r_weight[sc5_pkg::CLS_KNIGHT]   <= i_cfg_data[WEIGHT_BITS-1:0];
                default:
                    r_weight[sc5_pkg::CLS_DIAG_TWO] <= i_cfg_data[WEIGHT_BITS-1:0];
            endcase
        end else if (acc) begin
            if (x_last) begin
                r_x <= '0;
                r_y <= y_last ? 16'd0 : r_y + 16'd1;
            end else begin
                r_x <= r_x + XW'(1);
            end
        end
    end

    // ------------------------------------------------------- line memories
    sc5_line_buf #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_line_buf (
        .i_clk  (i_clk),
        .i_en   (acc),
        .i_addr (r_x),
        .i_lane (r_y[1:0]),
        .i_data (i_pixel_in),
        .o_data (lb_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (acc) begin
            r_b_valid <= 1'b1;
        end else if (b_load) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_pix <= i_pixel_in;
            r_b_x   <= r_x;
            r_b_y   <= r_y;
            r_b_xl  <= x_last;
            r_b_yl  <= y_last;
        end
    end

    // lane (y+i) mod 4 holds image row y-4+i
    always_comb begin
        for (int i = 0; i < sc5_pkg::LINES; i++) begin
            new_col[i] = lb_rd[2'(r_b_y[1:0] + 2'(i))];
        end
        new_col[TAPS-1] = r_b_pix;
    end

    // ------------------------------------------------------ job sequencing
    assign adv        = (r_cnt != 2'd2);
    assign issue      = r_act && adv;
    assign ri_end     = (r_ri == (r_rn_two ? 2'd2 : 2'd0));
    assign ci_end     = (r_ci == (r_cn_two ? 2'd2 : 2'd0));
    assign issue_last = issue && ri_end && ci_end;
    assign b_load     = r_b_valid && (!r_act || issue_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (b_load) begin
            r_act <= (r_b_y >= 16'd2) && (r_b_x >= XW'(2));
        end else if (issue_last) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_ri     <= 2'd0;
            r_ci     <= 2'd0;
            r_rn_two <= r_b_yl;
            r_cn_two <= r_b_xl;
            r_jy     <= r_b_y;
            r_jx     <= r_b_x;
            r_jlast  <= r_b_xl && r_b_yl;
        end else if (issue && !issue_last) begin
            if (ci_end) begin
                r_ci <= 2'd0;
                r_ri <= r_ri + 2'd1;
            end else begin
                r_ci <= r_ci + 2'd1;
            end
        end
    end

    always_comb begin
        for (int d = 0; d < TAPS; d++) begin
            row_tap[d] = sc5_pkg::mirror_tap(3'(r_ri) + 3'(d), r_jy == 16'd2, r_jy == 16'd3);
            col_tap[d] = sc5_pkg::mirror_tap(3'(r_ci) + 3'(d), r_jx == XW'(2), r_jx == XW'(3));
        end
        issue_meta.row        = r_jy - 16'd2 + 16'(r_ri);
        issue_meta.col        = sc5_pkg::t_col'(r_jx) - sc5_pkg::t_col'(2)
                              + sc5_pkg::t_col'(r_ci);
        issue_meta.run_last   = ri_end && ci_end;
        issue_meta.frame_done = ri_end && ci_end && r_jlast;
    end

    // ------------------------------------------------------- window cells
    for (genvar j = 0; j < TAPS; j++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] cin [TAPS];
        if (j == TAPS - 1) begin : g_head
            assign cin = new_col;
        end else begin : g_body
            assign cin = cell_col[j+1];
        end

        sc5_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_shift   (b_load),
            .i_col     (cin),
            .o_col     (cell_col[j]),
            .i_capture (issue),
            .i_row_tap (row_tap),
            .o_sel     (cell_sel[j])
        );
    end

    sc5_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (issue),
        .i_meta    (issue_meta),
        .i_col_tap (col_tap),
        .i_sel     (cell_sel),
        .i_weight  (r_weight),
        .o_valid   (mac_valid),
        .o_pixel   (mac_pixel),
        .o_meta    (mac_meta)
    );

    // -------------------------------------------------------- output queue
    assign push = mac_valid && adv;
    assign pop  = o_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q_pix[0]  <= (r_cnt == 2'd2) ? r_q_pix[1]  : mac_pixel;
            r_q_meta[0] <= (r_cnt == 2'd2) ? r_q_meta[1] : mac_meta;
            if (r_cnt == 2'd2 && push) begin
                r_q_pix[1]  <= mac_pixel;
                r_q_meta[1] <= mac_meta;
            end
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                r_q_pix[0]  <= mac_pixel;
                r_q_meta[0] <= mac_meta;
            end else begin
                r_q_pix[1]  <= mac_pixel;
                r_q_meta[1] <= mac_meta;
            end
        end
    end

    assign o_res_valid  = (r_cnt != 2'd0);
    assign o_pixel_out  = r_q_pix[0];
    assign o_out_row    = r_q_meta[0].row;
    assign o_out_col    = r_q_meta[0].col[XW-1:0];
    assign o_run_last   = r_q_meta[0].run_last;
    assign o_frame_done = r_q_meta[0].frame_done;

    // ---------------------------------------------------------- assertions
    `SC5_ASSERT_IMP(a_queue_bound, 1'b1, r_cnt != 2'd3, "output queue overflow")
    `SC5_ASSERT_IMP(a_done_last, o_res_valid && o_frame_done, o_run_last, "frame_done without run_last")
    `SC5_ASSERT_IMP(a_job_range, r_act, (r_ri <= (r_rn_two ? 2'd2 : 2'd0)) && (r_ci <= (r_cn_two ? 2'd2 : 2'd0)), "job index out of range")
    `SC5_ASSERT_NXT(a_job_hold, r_act && !adv, $stable(r_ri) && $stable(r_ci), "job moved while stalled")

endmodule

### tb/tb_symmetric_5x5_convolution_top.sv
// ----------------------------------------------------------------------------
// tb_symmetric_5x5_convolution_top
// Streams raster planes of random and extreme samples through the 5x5
// symmetric filter under several sizes and kernels, predicts every filtered
// sample with a behavioral line-buffer/window model and checks each result
// transfer field by field, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_symmetric_5x5_convolution_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW  = 2048;
    localparam int LIMIT = 1000000;
    localparam int TAPS  = sc5_pkg::TAPS;
    localparam int LINES = sc5_pkg::LINES;
    localparam int NCLS  = sc5_pkg::NCLS;

    typedef struct {
        logic signed [15:0] pixel;
        logic [15:0]        row;
        logic [10:0]        col;
        logic               run_last;
        logic               frame_done;
    } t_filtered;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [17:0]        i_cfg_data = '0;
    logic               i_pix_valid = 1'b0;
    logic               o_pix_ready;
    logic signed [15:0] i_pixel_in = '0;
    logic               o_res_valid;
    logic               i_res_ready = 1'b0;
    logic signed [15:0] o_pixel_out;
    logic [15:0]        o_out_row;
    logic [10:0]        o_out_col;
    logic               o_run_last;
    logic               o_frame_done;

    symmetric_5x5_convolution_top u_top (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    int          cfg_width, cfg_height;
    longint      kernel_w[NCLS];
    int          line_mem[LINES*MAXW];
    int          win[TAPS][TAPS];
    int          col_pos, row_pos;

    logic signed [15:0] sample_queue[$];
    t_filtered          filtered_queue[$];
    int                 errors = 0;
    int                 idle_pct = 11;
    bit                 hold = 1'b0;
    int                 cycles = 0;

    function automatic int mirror_idx(int v, int n);
        if (v < 0) v = -v - 1;
        if (v >= n) v = 2*n - 1 - v;
        if (v < 0) v = 0;
        if (v >= n) v = n - 1;
        return v;
    endfunction

    function automatic int clip_tap(int v);
        return v < 0 ? 0 : (v >= TAPS ? TAPS-1 : v);
    endfunction

    function automatic logic signed [15:0] kernel_sum(int r, int c, int y, int x, int w, int h);
        longint sum, q;
        int     wi, wj, ay, ax, cls;
        sum = 0;
        for (int dy = -2; dy <= 2; dy++) begin
            wi = clip_tap(mirror_idx(r + dy, h) - y + TAPS - 1);
            for (int dx = -2; dx <= 2; dx++) begin
                wj = clip_tap(mirror_idx(c + dx, w) - x + TAPS - 1);
                ay = dy < 0 ? -dy : dy;
                ax = dx < 0 ? -dx : dx;
                if (ay == 0 && ax == 0)      cls = sc5_pkg::CLS_CENTER;
                else if (ay + ax == 1)       cls = sc5_pkg::CLS_AXIS_ONE;
                else if (ay == 1 && ax == 1) cls = sc5_pkg::CLS_DIAG_ONE;
                else if (ay + ax == 2)       cls = sc5_pkg::CLS_AXIS_TWO;
                else if (ay + ax == 3)       cls = sc5_pkg::CLS_KNIGHT;
                else                         cls = sc5_pkg::CLS_DIAG_TWO;
                sum += longint'(win[wi][wj]) * kernel_w[cls];
            end
        end
        q = (sum + 64'sd32768) >>> 16;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    task automatic conv_step(logic signed [15:0] px);
        int w, h, x, y, r1, c1, total, n;
        t_filtered f;
        w = cfg_width < 3 ? 3 : (cfg_width > MAXW ? MAXW : cfg_width);
        h = cfg_height < 3 ? 3 : cfg_height;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        x = col_pos;
        y = row_pos;
        for (int i = 0; i < TAPS; i++)
            for (int j = 0; j < TAPS-1; j++) win[i][j] = win[i][j+1];
        for (int i = 0; i < LINES; i++) win[i][TAPS-1] = line_mem[((y + i) % LINES)*MAXW + x];
        win[TAPS-1][TAPS-1] = px;
        line_mem[(y % LINES)*MAXW + x] = px;
        if (y >= 2 && x >= 2) begin
            r1 = (y == h-1) ? y : y - 2;
            c1 = (x == w-1) ? x : x - 2;
            total = (r1 - y + 3) * (c1 - x + 3);
            n = 0;
            for (int r = y - 2; r <= r1; r++)
                for (int c = x - 2; c <= c1; c++) begin
                    n++;
                    f.pixel      = kernel_sum(r, c, y, x, w, h);
                    f.row        = 16'(r);
                    f.col        = 11'(c);
                    f.run_last   = (n == total);
                    f.frame_done = (n == total) && (y == h-1) && (x == w-1);
                    filtered_queue.push_back(f);
                end
        end
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (i_pix_valid && o_pix_ready) conv_step(i_pixel_in);
        if (!i_pix_valid || o_pix_ready) begin
            if (sample_queue.size() > 0 && !hold && $urandom_range(99) >= idle_pct) begin
                i_pix_valid <= 1'b1;
                i_pixel_in  <= sample_queue.pop_front();
            end else begin
                i_pix_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_filtered e;
        if (o_res_valid && i_res_ready) begin
            if (filtered_queue.size() == 0) begin
                report("unexpected transfer row", o_out_row, -1);
            end else begin
                e = filtered_queue.pop_front();
                if (o_pixel_out !== e.pixel) report("pixel_out", o_pixel_out, e.pixel);
                if (o_out_row !== e.row) report("out_row", o_out_row, e.row);
                if (o_out_col !== e.col) report("out_col", o_out_col, e.col);
                if (o_run_last !== e.run_last) report("run_last", o_run_last, e.run_last);
                if (o_frame_done !== e.frame_done)
                    report("frame_done", o_frame_done, e.frame_done);
            end
        end
        i_res_ready <= i_rst_n && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[symmetric_5x5_convolution_top] ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [17:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sc5_pkg::REG_FRAME_WIDTH: begin
                cfg_width = data[11:0];
                col_pos = 0;
                row_pos = 0;
            end
            sc5_pkg::REG_FRAME_HEIGHT: begin
                cfg_height = data[15:0];
                col_pos = 0;
                row_pos = 0;
            end
            default: kernel_w[idx - sc5_pkg::REG_WEIGHT_CENTER] = longint'($signed(data));
        endcase
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (sample_queue.size() > 0 || i_pix_valid || filtered_queue.size() > 0);
        repeat (16) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_pixel();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [17:0] rand_weight();
        case ($urandom_range(5))
            0:       return 18'h1ffff;
            1:       return 18'h20000;
            2:       return 18'($urandom);
            default: return 18'($signed(15'($urandom)));
        endcase
    endfunction

    task automatic set_kernel();
        for (int k = 0; k < NCLS; k++)
            write_reg(3'(sc5_pkg::REG_WEIGHT_CENTER + k), rand_weight());
    endtask

    task automatic push_samples(int n);
        for (int i = 0; i < n; i++) sample_queue.push_back(rand_pixel());
    endtask

    initial begin
        int w, h, fed;
        bit pressed;
        pressed    = 1'b0;
        cfg_width  = 2048;
        cfg_height = 3;
        foreach (kernel_w[k]) kernel_w[k] = 0;
        kernel_w[sc5_pkg::CLS_CENTER] = 65536;
        foreach (line_mem[k]) line_mem[k] = 0;
        foreach (win[i, j]) win[i][j] = 0;
        col_pos = 0;
        row_pos = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: full-width plane, start of the first row; no idling
        // from here through the clamped-size planes
        idle_pct = 0;
        push_samples(40);
        wait_idle();

        // undersized registers clamp to 3x3; saturating kernels
        write_reg(sc5_pkg::REG_FRAME_WIDTH, 18'h3f000);
        write_reg(sc5_pkg::REG_FRAME_HEIGHT, 18'h30000);
        for (int k = 0; k < NCLS; k++)
            write_reg(3'(sc5_pkg::REG_WEIGHT_CENTER + k), 18'h1ffff);
        for (int i = 0; i < 9; i++) sample_queue.push_back(i[0] ? 16'sh7fff : 16'sh8000);
        wait_idle();
        for (int k = 0; k < NCLS; k++)
            write_reg(3'(sc5_pkg::REG_WEIGHT_CENTER + k), 18'h20000);
        for (int i = 0; i < 9; i++) sample_queue.push_back(i < 5 ? 16'sh7fff : 16'sh8000);
        wait_idle();

        // oversized width clamps to the maximum; tallest plane, partly fed
        write_reg(sc5_pkg::REG_FRAME_WIDTH, 18'h00fff);
        write_reg(sc5_pkg::REG_FRAME_HEIGHT, 18'h0ffff);
        set_kernel();
        push_samples(20);
        wait_idle();
        idle_pct = 11;

        // random planes, the odd one cut short by a size change
        fed = 0;
        while (fed < 120) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            write_reg(sc5_pkg::REG_FRAME_WIDTH, 18'(w));
            write_reg(sc5_pkg::REG_FRAME_HEIGHT, 18'(h));
            set_kernel();
            if (!pressed || $urandom_range(3) == 0) begin
                // sender waits mid-plane until every pending result is out
                pressed = 1'b1;
                push_samples(w*2 + 3);
                fed += w*2 + 3;
                do @(posedge i_clk); while (sample_queue.size() > 0 || i_pix_valid);
                hold = 1'b1;
                while (filtered_queue.size() > 0) @(posedge i_clk);
                hold = 1'b0;
                push_samples(w*h - w*2 - 3);
            end else if ($urandom_range(4) == 0) begin
                push_samples($urandom_range(1, w*h - 1));
            end else begin
                push_samples(w*h);
            end
            fed += sample_queue.size();
            wait_idle();
        end

        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("[symmetric_5x5_convolution_top] OK");
        end else begin
            $display("[symmetric_5x5_convolution_top] ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/sc5_pkg.sv
rtl/sc5_line_buf.sv
rtl/sc5_cell.sv
rtl/sc5_mac.sv
rtl/symmetric_5x5_convolution_top.sv
tb/tb_symmetric_5x5_convolution_top.sv
